### hdl/mtg_pkg.sv
// Shared types, constants and helper functions of the MT19937-64 generator.
`timescale 1ns / 1ps
package mtg_pkg;

    localparam int STATE_WORDS   = 312;
    localparam int MIDDLE_OFFSET = 156;
    localparam int SAW           = 9;

    localparam logic [SAW-1:0] IDX_LAST     = 9'd311;
    localparam logic [SAW-1:0] IDX_FULL     = 9'd312;
    localparam logic [SAW-1:0] IDX_UNSEEDED = 9'd313;
    localparam logic [SAW-1:0] IDX_MIDDLE   = 9'd156;

    localparam logic [63:0] SEED_MULT     = 64'd6364136223846793005;
    localparam logic [63:0] ARR_MULT1     = 64'd3935559000370003845;
    localparam logic [63:0] ARR_MULT2     = 64'd2862933555777941757;
    localparam logic [63:0] ARR_BASE_SEED = 64'd19650218;
    localparam logic [63:0] DEFAULT_SEED  = 64'd5489;
    localparam logic [63:0] TWIST_MATRIX  = 64'hB5026F5AA96619E9;
    localparam logic [63:0] TOP_BIT       = 64'h8000000000000000;
    localparam logic [63:0] TEMPER_D      = 64'h5555555555555555;
    localparam logic [63:0] TEMPER_B      = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TEMPER_C      = 64'hFFF7EEE000000000;

    typedef enum logic [1:0] {
        FUNC_GEN  = 2'd0,
        FUNC_SEED = 2'd1,
        FUNC_KEY  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_SEED  = 2'd0,
        MODE_ARRAY = 2'd1,
        MODE_GEN   = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_LIN0, S_LIN_MUL, S_LIN_WR,
        S_A1_RD, S_A1_MUL, S_A1_WR, S_A1_WRAP,
        S_A2_RD, S_A2_MUL, S_A2_WR, S_A2_WRAP, S_A_FIN,
        S_T_RD0, S_T_RD1, S_T_RD2, S_T_WR,
        S_G_RD, S_G_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    function automatic logic [63:0] fold62(input logic [63:0] p);
        return p ^ (p >> 62);
    endfunction

    function automatic logic [63:0] temper(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ ((x >> 29) & TEMPER_D);
        x = x ^ ((x << 17) & TEMPER_B);
        x = x ^ ((x << 37) & TEMPER_C);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

### hdl/mtg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module mtg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mtg_mul.sv
// 64x64 low-half multiplier built from one 32x32 multiplier used in turn.
`timescale 1ns / 1ps
module mtg_mul
    import mtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mul_req    i_req,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_ph;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;

    // low x low, high x low, low x high; upper cross terms fall off the top
    always_comb begin
        case (r_ph)
            2'd1:    begin mx = r_a[63:32]; my = r_b[31:0];  end
            2'd2:    begin mx = r_a[31:0];  my = r_b[63:32]; end
            default: begin mx = r_a[31:0];  my = r_b[31:0];  end
        endcase
    end

    assign prod = {32'd0, mx} * {32'd0, my};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_ph   <= 2'd0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            if (r_ph == 2'd0) begin
                r_acc <= prod;
            end else begin
                r_acc <= r_acc + {prod[31:0], 32'd0};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hdl/mersenne_twister_64_generator_unit.sv
// Top level of the MT19937-64 generator: request sequencer, state and key stores.
`timescale 1ns / 1ps
// MT19937-64 generator. Each request carries func in tuser (0 generate, 1 seed,
// 2 key word), the seed or key word in tdata and the final-key flag in tlast.
// Only generate requests return a word. The 312-word state sits in one RAM whose
// ports are used one access at a time; every operation walks it one word at a
// time, so timing is set by that RAM and by the shared 64-bit multiplier. A
// generate request with words left reads the word and then tempers it into the
// result register. When the store is used up, the twist runs first, with three
// reads and a write per word. A seed request runs the linear seed, which writes
// the state one word and one multiply at a time; the last key word of a key runs
// the linear seed and then the two passes of array seeding. A generate before any
// seed first seeds with 5489. Key words past MAX_KEY_WORDS are dropped. The
// result register holds one word, so a new request is taken while it waits.
module mersenne_twister_64_generator_unit
    import mtg_pkg::*;
#(
    parameter int MAX_KEY_WORDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] random_word
);

    localparam int KCW = $clog2(MAX_KEY_WORDS + 1);
    localparam int KAW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

    t_state          r_state, n_state;
    t_mode           r_mode, n_mode;
    logic [SAW-1:0]  r_n, n_n;        // word index for seeding and twist
    logic [KAW-1:0]  r_b, n_b;        // key index during array seeding
    logic [SAW-1:0]  r_cnt, n_cnt;
    logic [63:0]     r_prev, n_prev;  // last word written, state[n-1]
    logic [63:0]     r_xhi, n_xhi;
    logic [63:0]     r_xlo, n_xlo;
    logic [SAW-1:0]  r_ridx, n_ridx;
    logic [KCW-1:0]  r_kc, n_kc;
    logic [KCW-1:0]  r_len, n_len;
    logic [63:0]     r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            accept;
    t_func           func;
    logic            out_free;

    logic            st_we, st_re;
    logic [SAW-1:0]  st_waddr, st_raddr;
    logic [63:0]     st_wdata, st_rdata;
    logic            key_we;
    logic [KAW-1:0]  key_waddr;
    logic [63:0]     key_rdata;

    t_mul_req        mreq;
    logic            mul_done;
    logic [63:0]     mul_prod;

    logic [63:0]     lin_word, a1_word, a2_word, tw_word, tw_x;
    logic [SAW-1:0]  nx_idx, md_idx, n_inc;
    logic [SAW:0]    md_sum;
    logic [KCW-1:0]  b_inc, kc_inc;
    logic [SAW-1:0]  cnt_dec;
    logic            key_room;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign func            = t_func'(i_s_axis_tuser);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign key_room        = (r_kc < KCW'(MAX_KEY_WORDS));
    assign kc_inc          = r_kc + KCW'(1);

    mtg_ram #(.WIDTH(64), .DEPTH(STATE_WORDS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign key_we    = accept && (func == FUNC_KEY) && key_room;
    assign key_waddr = r_kc[KAW-1:0];

    mtg_ram #(.WIDTH(64), .DEPTH(MAX_KEY_WORDS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (r_state == S_A1_RD),
        .i_raddr (r_b),
        .o_rdata (key_rdata)
    );

    mtg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Word arithmetic for each walk
    assign lin_word = mul_prod + {{(64-SAW){1'b0}}, r_n};
    assign a1_word  = (st_rdata ^ mul_prod) + key_rdata + {{(64-KAW){1'b0}}, r_b};
    assign a2_word  = (st_rdata ^ mul_prod) - {{(64-SAW){1'b0}}, r_n};
    assign tw_x     = {r_xhi[63:31], r_xlo[30:0]};
    assign tw_word  = st_rdata ^ (tw_x >> 1) ^ (tw_x[0] ? TWIST_MATRIX : 64'd0);

    assign n_inc   = r_n + SAW'(1);
    assign nx_idx  = (r_n == IDX_LAST) ? '0 : n_inc;
    assign md_sum  = {1'b0, r_n} + {1'b0, IDX_MIDDLE};
    assign md_idx  = (md_sum >= {1'b0, IDX_FULL}) ? SAW'(md_sum - {1'b0, IDX_FULL})
                                                  : md_sum[SAW-1:0];
    assign b_inc   = KCW'(r_b) + KCW'(1);
    assign cnt_dec = r_cnt - SAW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_GEN: begin
                            if (r_ridx == IDX_UNSEEDED) n_state = S_LIN0;
                            else if (r_ridx == IDX_FULL) n_state = S_T_RD0;
                            else n_state = S_G_RD;
                        end
                        FUNC_SEED: n_state = S_LIN0;
                        FUNC_KEY:  if (i_s_axis_tlast) n_state = S_LIN0;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LIN0:    n_state = S_LIN_MUL;
            S_LIN_MUL: if (mul_done) n_state = S_LIN_WR;
            S_LIN_WR: begin
                if (r_n != IDX_LAST) n_state = S_LIN_MUL;
                else if (r_mode == MODE_ARRAY) n_state = S_A1_RD;
                else if (r_mode == MODE_GEN) n_state = S_T_RD0;
                else n_state = S_IDLE;
            end
            S_A1_RD:  n_state = S_A1_MUL;
            S_A1_MUL: if (mul_done) n_state = S_A1_WR;
            S_A1_WR: begin
                if (r_n == IDX_LAST) n_state = S_A1_WRAP;
                else if (cnt_dec == '0) n_state = S_A2_RD;
                else n_state = S_A1_RD;
            end
            S_A1_WRAP: n_state = (r_cnt == '0) ? S_A2_RD : S_A1_RD;
            S_A2_RD:   n_state = S_A2_MUL;
            S_A2_MUL:  if (mul_done) n_state = S_A2_WR;
            S_A2_WR: begin
                if (r_n == IDX_LAST) n_state = S_A2_WRAP;
                else if (cnt_dec == '0) n_state = S_A_FIN;
                else n_state = S_A2_RD;
            end
            S_A2_WRAP: n_state = (r_cnt == '0) ? S_A_FIN : S_A2_RD;
            S_A_FIN:   n_state = S_IDLE;
            S_T_RD0:   n_state = S_T_RD1;
            S_T_RD1:   n_state = S_T_RD2;
            S_T_RD2:   n_state = S_T_WR;
            S_T_WR:    n_state = (r_n == IDX_LAST) ? S_G_RD : S_T_RD0;
            S_G_RD:    n_state = S_G_OUT;
            S_G_OUT:   if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        n_mode      = r_mode;
        n_n         = r_n;
        n_b         = r_b;
        n_cnt       = r_cnt;
        n_prev      = r_prev;
        n_xhi       = r_xhi;
        n_xlo       = r_xlo;
        n_ridx      = r_ridx;
        n_kc        = r_kc;
        n_len       = r_len;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        st_we       = 1'b0;
        st_waddr    = r_n;
        st_wdata    = r_prev;
        st_re       = 1'b0;
        st_raddr    = r_n;
        mreq.start  = 1'b0;
        mreq.a      = fold62(r_prev);
        mreq.b      = SEED_MULT;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_GEN: begin
                            n_n = '0;
                            if (r_ridx == IDX_UNSEEDED) begin
                                n_prev = DEFAULT_SEED;
                                n_mode = MODE_GEN;
                            end
                        end
                        FUNC_SEED: begin
                            n_prev = i_s_axis_tdata;
                            n_mode = MODE_SEED;
                        end
                        FUNC_KEY: begin
                            if (key_room) n_kc = kc_inc;
                            if (i_s_axis_tlast) begin
                                n_len  = key_room ? kc_inc : r_kc;
                                n_prev = ARR_BASE_SEED;
                                n_mode = MODE_ARRAY;
                            end
                        end
                        default: n_mode = r_mode;
                    endcase
                end
            end
            S_LIN0: begin
                st_we      = 1'b1;
                st_waddr   = '0;
                mreq.start = 1'b1;
                n_n        = SAW'(1);
            end
            S_LIN_MUL: n_n = r_n;
            S_LIN_WR: begin
                st_we    = 1'b1;
                st_wdata = lin_word;
                n_prev   = lin_word;
                if (r_n != IDX_LAST) begin
                    mreq.start = 1'b1;
                    mreq.a     = fold62(lin_word);
                    n_n        = n_inc;
                end else if (r_mode == MODE_ARRAY) begin
                    n_prev = ARR_BASE_SEED;
                    n_n    = SAW'(1);
                    n_b    = '0;
                    n_cnt  = IDX_FULL;
                end else if (r_mode == MODE_GEN) begin
                    n_n = '0;
                end else begin
                    n_ridx = IDX_FULL;
                end
            end
            S_A1_RD, S_A2_RD: begin
                st_re      = 1'b1;
                mreq.start = 1'b1;
                mreq.b     = (r_state == S_A1_RD) ? ARR_MULT1 : ARR_MULT2;
            end
            S_A1_MUL, S_A2_MUL: n_n = r_n;
            S_A1_WR, S_A2_WR: begin
                st_we    = 1'b1;
                st_wdata = (r_state == S_A1_WR) ? a1_word : a2_word;
                n_prev   = st_wdata;
                n_n      = n_inc;
                n_cnt    = cnt_dec;
                if (r_state == S_A1_WR) begin
                    n_b = (b_inc >= r_len) ? '0 : b_inc[KAW-1:0];
                    if (r_n != IDX_LAST && cnt_dec == '0) n_cnt = IDX_LAST;
                end
            end
            S_A1_WRAP, S_A2_WRAP: begin
                // state[0] takes the copy of state[311], which r_prev holds
                st_we    = 1'b1;
                st_waddr = '0;
                n_n      = SAW'(1);
                if (r_state == S_A1_WRAP && r_cnt == '0) n_cnt = IDX_LAST;
            end
            S_A_FIN: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = TOP_BIT;
                n_ridx   = IDX_FULL;
                n_kc     = '0;
            end
            S_T_RD0: st_re = 1'b1;
            S_T_RD1: begin
                st_re    = 1'b1;
                st_raddr = nx_idx;
                n_xhi    = st_rdata;
            end
            S_T_RD2: begin
                st_re    = 1'b1;
                st_raddr = md_idx;
                n_xlo    = st_rdata;
            end
            S_T_WR: begin
                st_we    = 1'b1;
                st_wdata = tw_word;
                n_n      = n_inc;
                if (r_n == IDX_LAST) n_ridx = '0;
            end
            S_G_RD: begin
                st_re    = 1'b1;
                st_raddr = r_ridx;
            end
            S_G_OUT: begin
                if (out_free) begin
                    n_out       = temper(st_rdata);
                    n_out_valid = 1'b1;
                    n_ridx      = r_ridx + SAW'(1);
                end
            end
            default: n_n = r_n;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_SEED;
            r_ridx      <= IDX_UNSEEDED;
            r_kc        <= '0;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_b         <= '0;
            r_cnt       <= '0;
            r_len       <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_ridx      <= n_ridx;
            r_kc        <= n_kc;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_b         <= n_b;
            r_cnt       <= n_cnt;
            r_len       <= n_len;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_xhi  <= n_xhi;
        r_xlo  <= n_xlo;
        r_out  <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // The state RAM port is never read and written in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st_we && st_re))
        else $error("state RAM read and write collide");

    a_ridx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ridx <= IDX_UNSEEDED)
        else $error("read index out of range");

    a_kc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kc <= KCW'(MAX_KEY_WORDS))
        else $error("key count beyond key store");

    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_LIN_MUL || r_state == S_A1_MUL ||
                      r_state == S_A2_MUL))
        else $error("product ready outside a multiply wait");

endmodule
